// ===== rtl/nmit_pkg.sv =====
// Package: shared widths, types and the cofactor operand table of the normal matrix core.
`default_nettype none
package nmit_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 32;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int COF_W         = PROD_W + 1;
    localparam int TERM_W        = COF_W + ELEM_W;
    localparam int DET_W         = TERM_W + 2;
    localparam int QUO_W         = ELEM_W + 1;
    localparam int LO_W          = COF_W - ELEM_W;
    localparam int NUM_ELEM      = 9;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [DET_W-1:0]  t_det;

    typedef int t_cof_idx [NUM_ELEM][4];

    // cofactor k = a[p]*a[q] - a[r]*a[s], row-major element indices
    localparam t_cof_idx COF_IDX = '{
        '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
        '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
        '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
    };

endpackage
`default_nettype wire

// ===== rtl/nmit_if.sv =====
// Interfaces: input matrix channel, normal matrix result channel, threshold write channel.
`default_nettype none
interface nmit_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface nmit_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] n00, n01, n02, n10, n11, n12, n20, n21, n22;
    logic singular;
    logic saturated;
    modport source (output valid, n00, n01, n02, n10, n11, n12, n20, n21, n22,
                    singular, saturated, input ready);
    modport sink   (input valid, n00, n01, n02, n10, n11, n12, n20, n21, n22,
                    singular, saturated, output ready);
endinterface

interface nmit_cfg_if;
    logic valid;
    logic ready;
    logic [31:0] singular_threshold;
    modport source (output valid, singular_threshold, input ready);
    modport sink   (input valid, singular_threshold, output ready);
endinterface
`default_nettype wire

// ===== rtl/nmit_div.sv =====
// Pipelined restoring divider: one element of cofactor / determinant, rounded and saturated.
`default_nettype none
module nmit_div #(
    parameter int FRAC_BITS = nmit_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [nmit_pkg::COF_W-1:0]    i_cm,
    input  wire logic [nmit_pkg::DET_W-1:0]    i_dm,
    input  wire logic                          i_neg,
    output logic [nmit_pkg::ELEM_W-1:0]        o_elem,
    output logic                               o_sat
);
    localparam int QB    = nmit_pkg::QUO_W;
    localparam int NUM_W = nmit_pkg::COF_W + 2 * FRAC_BITS + 2;
    localparam int DEN_W = nmit_pkg::DET_W + QB + 2;
    localparam int W_R   = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    logic [W_R-1:0] r_rem [0:QB];
    logic [W_R-1:0] r_den [0:QB];
    logic [QB-1:0]  r_q   [0:QB];
    logic           r_ovf [0:QB];
    logic           r_neg [0:QB];

    logic [W_R-1:0] n_num;
    logic [W_R-1:0] n_den;

    assign n_num = ({{(W_R-nmit_pkg::COF_W){1'b0}}, i_cm} << (2 * FRAC_BITS + 1))
                 + {{(W_R-nmit_pkg::DET_W){1'b0}}, i_dm};
    assign n_den = {{(W_R-nmit_pkg::DET_W-1){1'b0}}, i_dm, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_num;
            r_den[0] <= n_den;
            r_q[0]   <= '0;
            r_ovf[0] <= (n_num >= (n_den << QB));
            r_neg[0] <= i_neg;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [W_R-1:0] n_trial;
        logic           n_take;
        assign n_trial = r_den[k-1] << (QB - k);
        assign n_take  = !r_ovf[k-1] && (r_rem[k-1] >= n_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_take ? (r_rem[k-1] - n_trial) : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= r_q[k-1] | (QB'(n_take) << (QB - k));
                r_ovf[k] <= r_ovf[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    logic [QB-1:0] n_lim;
    logic          n_clip;
    logic [QB-1:0] n_mag;

    assign n_lim  = r_neg[QB] ? (QB'(1) << (nmit_pkg::ELEM_W - 1))
                              : ((QB'(1) << (nmit_pkg::ELEM_W - 1)) - QB'(1));
    assign n_clip = r_ovf[QB] || (r_q[QB] > n_lim);
    assign n_mag  = n_clip ? n_lim : r_q[QB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_elem <= r_neg[QB] ? nmit_pkg::ELEM_W'(~n_mag + QB'(1))
                                : nmit_pkg::ELEM_W'(n_mag);
            o_sat  <= n_clip;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/normal_matrix_inverse_transpose_core.sv =====
// Top level: normal matrix (inverse transpose of a 3x3) pipeline with singular detection.
`default_nettype none
// Takes one 3x3 matrix per cycle and returns its normal matrix through seven cofactor
// and determinant stages and a 35-stage divider that resolves one quotient bit per stage
// for all nine elements in parallel. A stall on the output freezes the whole pipeline.
// The user must write the singular threshold only while idle; this is not enforced.
module normal_matrix_inverse_transpose_core #(
    parameter int FRAC_BITS = nmit_pkg::FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nmit_in_if.sink    i_in,
    nmit_cfg_if.sink   i_cfg,
    nmit_out_if.source o_out
);
    localparam int NE      = nmit_pkg::NUM_ELEM;
    localparam int FRONT   = 7;
    localparam int DIV_LAT = nmit_pkg::QUO_W + 2;
    localparam int LAT     = FRONT + DIV_LAT;
    localparam int LO_W    = nmit_pkg::LO_W;
    localparam int EW      = nmit_pkg::ELEM_W;

    logic [31:0] r_thr_val;
    logic [LAT-1:0] r_vld;
    logic [DIV_LAT-1:0] r_sing;
    logic en;

    assign en          = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_val <= 32'd1;
        end else if (i_cfg.valid) begin
            r_thr_val <= i_cfg.singular_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    nmit_pkg::t_elem a [NE];
    always_comb begin
        a[0] = i_in.a00; a[1] = i_in.a01; a[2] = i_in.a02;
        a[3] = i_in.a10; a[4] = i_in.a11; a[5] = i_in.a12;
        a[6] = i_in.a20; a[7] = i_in.a21; a[8] = i_in.a22;
    end

    nmit_pkg::t_prod r_p  [2*NE];
    nmit_pkg::t_elem r_a1 [3];
    nmit_pkg::t_cof  r_c2 [NE];
    nmit_pkg::t_elem r_a2 [3];
    logic signed [LO_W+EW:0]  r_plo [3];
    nmit_pkg::t_prod          r_phi [3];
    nmit_pkg::t_cof  r_c3 [NE];
    nmit_pkg::t_term r_t  [3];
    nmit_pkg::t_cof  r_c4 [NE];
    nmit_pkg::t_det  r_s;
    nmit_pkg::t_det  r_t2;
    nmit_pkg::t_cof  r_c5 [NE];
    nmit_pkg::t_det  r_det;
    nmit_pkg::t_cof  r_c6 [NE];
    logic [nmit_pkg::DET_W-1:0] r_dm;
    logic [nmit_pkg::COF_W-1:0] r_cm [NE];
    logic            r_neg [NE];

    for (genvar k = 0; k < NE; k++) begin : g_cof
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p[2*k]   <= a[nmit_pkg::COF_IDX[k][0]] * a[nmit_pkg::COF_IDX[k][1]];
                r_p[2*k+1] <= a[nmit_pkg::COF_IDX[k][2]] * a[nmit_pkg::COF_IDX[k][3]];
                r_c2[k]    <= nmit_pkg::t_cof'(r_p[2*k]) - nmit_pkg::t_cof'(r_p[2*k+1]);
                r_c3[k]    <= r_c2[k];
                r_c4[k]    <= r_c3[k];
                r_c5[k]    <= r_c4[k];
                r_c6[k]    <= r_c5[k];
                r_cm[k]    <= r_c6[k][nmit_pkg::COF_W-1] ? (~r_c6[k] + 1'b1) : r_c6[k];
                r_neg[k]   <= r_c6[k][nmit_pkg::COF_W-1] ^ r_det[nmit_pkg::DET_W-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_det
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a1[k]  <= a[k];
                r_a2[k]  <= r_a1[k];
                r_plo[k] <= $signed({1'b0, r_c2[k][LO_W-1:0]}) * r_a2[k];
                r_phi[k] <= $signed(r_c2[k][nmit_pkg::COF_W-1:LO_W]) * r_a2[k];
                r_t[k]   <= (nmit_pkg::t_term'(r_phi[k]) <<< LO_W)
                          + nmit_pkg::t_term'(r_plo[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s   <= nmit_pkg::t_det'(r_t[0]) + nmit_pkg::t_det'(r_t[1]);
            r_t2  <= nmit_pkg::t_det'(r_t[2]);
            r_det <= r_s + r_t2;
            r_dm  <= r_det[nmit_pkg::DET_W-1] ? (~r_det + 1'b1) : r_det;
        end
    end

    logic [nmit_pkg::DET_W-1:0] n_lim;
    assign n_lim = nmit_pkg::DET_W'({r_thr_val, {(2*FRAC_BITS){1'b0}}});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing <= {r_sing[DIV_LAT-2:0], (n_lim >= r_dm)};
        end
    end

    logic [EW-1:0] q_elem [NE];
    logic [NE-1:0] q_sat;

    for (genvar k = 0; k < NE; k++) begin : g_div
        nmit_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cm   (r_cm[k]),
            .i_dm   (r_dm),
            .i_neg  (r_neg[k]),
            .o_elem (q_elem[k]),
            .o_sat  (q_sat[k])
        );
    end

    logic [EW-1:0] n_out [NE];
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            if (r_sing[DIV_LAT-1]) begin
                n_out[k] = (k % 4 == 0) ? (EW'(1) << FRAC_BITS) : '0;
            end else begin
                n_out[k] = q_elem[k];
            end
        end
    end

    assign o_out.valid     = r_vld[LAT-1];
    assign o_out.singular  = r_sing[DIV_LAT-1];
    assign o_out.saturated = !r_sing[DIV_LAT-1] && (|q_sat);
    assign o_out.n00 = n_out[0];
    assign o_out.n01 = n_out[1];
    assign o_out.n02 = n_out[2];
    assign o_out.n10 = n_out[3];
    assign o_out.n11 = n_out[4];
    assign o_out.n12 = n_out[5];
    assign o_out.n20 = n_out[6];
    assign o_out.n21 = n_out[7];
    assign o_out.n22 = n_out[8];

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the normal matrix core: random and directed matrices checked against a predictor.
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        nmit_pkg::t_elem a [9];
    } matrix_t;

    typedef struct {
        nmit_pkg::t_elem n [9];
        bit    singular;
        bit    saturated;
    } normal_t;

    class normal_scoreboard;
        logic [31:0] threshold;
        normal_t     pending [$];
        int          fails;

        function new();
            threshold = 32'd1;
            fails = 0;
        endfunction

        function automatic normal_t inverse_transpose(matrix_t m);
            int          ix [9][4] = '{'{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
                                       '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
                                       '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}};
            logic signed [127:0] e [9];
            logic signed [127:0] cf [9];
            logic signed [127:0] det;
            logic [127:0] dmag, cmag, num, quo, cap, lim;
            bit          neg;
            normal_t     r;
            for (int i = 0; i < 9; i++) e[i] = m.a[i];
            for (int k = 0; k < 9; k++)
                cf[k] = e[ix[k][0]] * e[ix[k][1]] - e[ix[k][2]] * e[ix[k][3]];
            det = cf[0] * e[0] + cf[1] * e[1] + cf[2] * e[2];
            dmag = det < 0 ? -det : det;
            lim = {64'd0, threshold, 32'd0};
            r.saturated = 0;
            if (dmag <= lim) begin
                for (int i = 0; i < 9; i++) r.n[i] = (i % 4 == 0) ? 32'sd65536 : 32'sd0;
                r.singular = 1;
                return r;
            end
            r.singular = 0;
            for (int k = 0; k < 9; k++) begin
                neg = (cf[k] < 0) != (det < 0);
                cmag = cf[k] < 0 ? -cf[k] : cf[k];
                num = (cmag << 33) + dmag;
                quo = num / (dmag << 1);
                cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                if (quo > cap) begin
                    quo = cap;
                    r.saturated = 1;
                end
                r.n[k] = neg ? -quo[31:0] : quo[31:0];
            end
            return r;
        endfunction

        function void note_matrix(matrix_t m);
            pending.push_back(inverse_transpose(m));
        endfunction

        function void check_normal(normal_t got);
            string   names [9] = '{"n00", "n01", "n02", "n10", "n11", "n12",
                                   "n20", "n21", "n22"};
            normal_t exp_n;
            if (pending.size() == 0) begin
                $error("result with no matrix outstanding");
                fails++;
                return;
            end
            exp_n = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.n[i] !== exp_n.n[i]) begin
                    $error("%s: expected %h, got %h", names[i], exp_n.n[i], got.n[i]);
                    fails++;
                end
            if (got.singular !== exp_n.singular) begin
                $error("singular: expected %b, got %b", exp_n.singular, got.singular);
                fails++;
            end
            if (got.saturated !== exp_n.saturated) begin
                $error("saturated: expected %b, got %b", exp_n.saturated, got.saturated);
                fails++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    nmit_in_if  in_if ();
    nmit_out_if out_if ();
    nmit_cfg_if cfg_if ();

    normal_matrix_inverse_transpose_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    normal_scoreboard sb = new();
    bit  busy_phase;
    int  idle_cycles;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int r;
        if (busy_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        normal_t got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.n = '{out_if.n00, out_if.n01, out_if.n02, out_if.n10, out_if.n11,
                      out_if.n12, out_if.n20, out_if.n21, out_if.n22};
            got.singular = out_if.singular;
            got.saturated = out_if.saturated;
            sb.check_normal(got);
        end
        out_if.ready <= busy_phase ? 1'b1 : (pick_gap() == 0);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_matrix(matrix_t m, int gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        {in_if.a00, in_if.a01, in_if.a02, in_if.a10, in_if.a11, in_if.a12,
         in_if.a20, in_if.a21, in_if.a22} <= {m.a[0], m.a[1], m.a[2], m.a[3], m.a[4],
                                              m.a[5], m.a[6], m.a[7], m.a[8]};
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_matrix(m);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [31:0] thr);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.singular_threshold <= thr;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sb.threshold = thr;
    endtask

    function automatic matrix_t random_matrix();
        matrix_t m;
        int      kind = $urandom_range(0, 9);
        nmit_pkg::t_elem picks [6] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, -1,
                                       32'sh0001_0000};
        for (int i = 0; i < 9; i++) begin
            if (kind < 5)
                m.a[i] = $signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
            else if (kind < 7)
                m.a[i] = $urandom;
            else if (kind == 7)
                m.a[i] = $signed($urandom_range(0, 511)) - 256;
            else
                m.a[i] = picks[$urandom_range(0, 5)];
        end
        if (kind == 4) begin
            for (int i = 0; i < 3; i++)
                m.a[6 + i] = m.a[i] + $signed($urandom_range(0, 3)) - 1;
        end
        return m;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) busy_phase = ($urandom_range(0, 3) == 0);
            send_matrix(random_matrix(), pick_gap());
        end
        busy_phase = 0;
    endtask

    initial begin
        nmit_pkg::t_elem one = 32'sh0001_0000;
        nmit_pkg::t_elem mx = 32'sh7FFF_FFFF;
        nmit_pkg::t_elem mn = 32'sh8000_0000;
        matrix_t dir [$];
        busy_phase = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        {in_if.a00, in_if.a01, in_if.a02, in_if.a10, in_if.a11, in_if.a12,
         in_if.a20, in_if.a21, in_if.a22} = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.singular_threshold = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir.push_back('{a: '{one, 0, 0, 0, one, 0, 0, 0, one}});
        dir.push_back('{a: '{2 * one, 0, 0, 0, 4 * one, 0, 0, 0, -8 * one}});
        dir.push_back('{a: '{0, 0, 0, 0, 0, 0, 0, 0, 0}});
        dir.push_back('{a: '{mx, 0, 0, 0, mx, 0, 0, 0, mx}});
        dir.push_back('{a: '{mn, 0, 0, 0, mn, 0, 0, 0, mn}});
        dir.push_back('{a: '{mn, mx, mn, mx, mn, mx, mn, mx, mn}});
        dir.push_back('{a: '{mx, mn, 0, 0, mx, mn, mn, 0, mx}});
        dir.push_back('{a: '{one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, one}});
        dir.push_back('{a: '{1, 0, 0, 0, 1, 0, 0, 0, 1}});
        dir.push_back('{a: '{32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0, 32'sh100}});
        dir.push_back('{a: '{32'sh1000, 0, 0, 0, 32'sh1000, 0, 0, 0, 32'sh1000}});
        dir.push_back('{a: '{one, 0, 0, 0, one, 0, 0, 0, 3}});
        dir.push_back('{a: '{3 * one, one, 0, -one, 2 * one, one, 0, one, 3 * one}});
        dir.push_back('{a: '{0, one, 0, 0, 0, one, one, 0, 0}});
        dir.push_back('{a: '{-1, -1, -1, -1, -1, -1, -1, -1, -1}});
        dir.push_back('{a: '{one, one, 0, 0, one, one, one, 0, one}});
        foreach (dir[i]) send_matrix(dir[i], pick_gap());

        write_threshold(32'd0);
        send_matrix('{a: '{1, 0, 0, 0, 1, 0, 0, 0, 1}}, 0);
        send_matrix('{a: '{one, 0, 0, 0, one, 0, 0, 0, 3}}, 0);
        random_phase(300);
        write_threshold(32'hFFFF_FFFF);
        send_matrix('{a: '{mn, 0, 0, 0, mn, 0, 0, 0, mn}}, 0);
        random_phase(120);
        write_threshold($urandom_range(2, 1 << 20));
        random_phase(300);
        write_threshold(32'd1);
        random_phase(300);
        write_threshold($urandom);
        random_phase(150);
        write_threshold(32'd0);
        random_phase(150);

        drain();
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
